// File: rtl/psfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfe_pkg: shared types and constants
// Status codes, result select codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package psfe_pkg;

    // Default depth of the held-back whitespace store
    localparam int SPACE_DEPTH_DEF = 32;

    // Reset value of the target field register
    localparam logic [31:0] TARGET_RESET = 32'd1;

    // Status codes carried on status items
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NULL      = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Output register load source
    localparam logic [1:0] SEL_FLUSH  = 2'd0;
    localparam logic [1:0] SEL_BYTE   = 2'd1;
    localparam logic [1:0] SEL_STATUS = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;    // input transaction taken this cycle
        logic       load;      // load output register
        logic [1:0] sel;       // output register source
        logic       run_last;  // last result of this item
        logic       rd_en;     // read whitespace store
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic has_byte;    // current input emits a string byte
        logic has_status;  // current input ends the message
        logic flush_any;   // held-back bytes go out before the byte
        logic last_hold;   // held item ended the message
        logic out_free;    // output register can take a result
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/psfe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfe_if: stream channel interfaces
// Input byte channel and output result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_last;

    modport source (output valid, output msg_byte, output msg_last, input ready);
    modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface psfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       run_last;

    modport source (output valid, output out_byte, output is_status,
                    output status_code, output run_last, input ready);
    modport sink   (input valid, input out_byte, input is_status,
                    input status_code, input run_last, output ready);
endinterface
`default_nettype wire

// File: rtl/psfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psfe_pkg::SPACE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/psfe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfe_ctrl: result sequencing controller
// Takes input transactions and orders the results of each one: held-back
// whitespace, then the string byte, then the end-of-message status.
// ----------------------------------------------------------------------------
module psfe_ctrl #(
    parameter int SPACE_DEPTH = psfe_pkg::SPACE_DEPTH_DEF,
    localparam int CNT_W  = $clog2(SPACE_DEPTH + 1),
    localparam int ADDR_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire psfe_pkg::stat_t     stat,
    input  wire logic [CNT_W-1:0]    flush_cnt,
    output psfe_pkg::cmd_t           cmd,
    output logic      [ADDR_W-1:0]   rd_addr
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FLUSH  = 2'd1;
    localparam logic [1:0] S_BYTE   = 2'd2;
    localparam logic [1:0] S_STATUS = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.accept   = accept;
        cmd.load     = 1'b0;
        cmd.sel      = psfe_pkg::SEL_BYTE;
        cmd.run_last = 1'b0;
        cmd.rd_en    = 1'b0;
        rd_addr      = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.flush_any)
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = '0;
                        idx_next   = CNT_W'(1);
                        state_next = S_FLUSH;
                    end
                    else if (stat.has_byte)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load     = 1'b1;
                            cmd.sel      = psfe_pkg::SEL_BYTE;
                            cmd.run_last = !stat.has_status;
                            state_next   = stat.has_status ? S_STATUS : S_IDLE;
                        end
                        else
                        begin
                            state_next = S_BYTE;
                        end
                    end
                    else if (stat.has_status)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load     = 1'b1;
                            cmd.sel      = psfe_pkg::SEL_STATUS;
                            cmd.run_last = 1'b1;
                        end
                        else
                        begin
                            state_next = S_STATUS;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = psfe_pkg::SEL_FLUSH;
                    if (idx_reg < flush_cnt)
                    begin
                        cmd.rd_en = 1'b1;
                        idx_next  = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_BYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.sel      = psfe_pkg::SEL_BYTE;
                    cmd.run_last = !stat.last_hold;
                    state_next   = stat.last_hold ? S_STATUS : S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.sel      = psfe_pkg::SEL_STATUS;
                    cmd.run_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/psfe_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfe_dpath: wire-format parser datapath
// Varint decode, key dispatch, field skip counting, whitespace store and
// the output result register.
// ----------------------------------------------------------------------------
module psfe_dpath #(
    parameter int SPACE_DEPTH = psfe_pkg::SPACE_DEPTH_DEF,
    localparam int CNT_W  = $clog2(SPACE_DEPTH + 1),
    localparam int ADDR_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [31:0]         target_field,
    input  wire logic [7:0]          msg_byte,
    input  wire logic                msg_last,
    input  wire psfe_pkg::cmd_t      cmd,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output psfe_pkg::stat_t          stat,
    output logic      [CNT_W-1:0]    flush_cnt,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic      [7:0]          out_byte,
    output logic                     is_status,
    output logic      [1:0]          status_code,
    output logic                     run_last
);

    // Parse phases
    localparam logic [2:0] PH_KEY      = 3'd0;
    localparam logic [2:0] PH_VARINT   = 3'd1;
    localparam logic [2:0] PH_LEN_SKIP = 3'd2;
    localparam logic [2:0] PH_LEN_TGT  = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd4;
    localparam logic [2:0] PH_STRING   = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;
    localparam logic [2:0] PH_BAD      = 3'd7;

    // Wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [7:0] WS_MAX    = 8'h20;
    localparam logic [6:0] SHIFT_MAX = 7'd70;
    localparam logic [6:0] SHIFT_STEP = 7'd7;

    logic [2:0]       phase_reg, phase_next;
    logic [63:0]      accum_reg, accum_next;
    logic [6:0]       shift_reg, shift_next;
    logic [63:0]      remain_reg, remain_next;
    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] pcount_reg, pcount_next;
    logic [1:0]       fstat_reg, fstat_next;

    logic [7:0]       byte_hold_reg;
    logic             last_hold_reg;
    logic [1:0]       code_hold_reg;
    logic [CNT_W-1:0] fcnt_hold_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             is_status_reg;
    logic [1:0]       status_code_reg;
    logic             run_last_reg;

    logic [63:0]      shifted;
    logic [63:0]      accum_take;
    logic [6:0]       shift_inc;
    logic             v_done;
    logic             v_long;
    logic [63:0]      remain_dec;
    logic             is_ws;
    logic             emit_byte;
    logic [1:0]       code_now;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic [7:0]       byte_val;
    logic [1:0]       code_val;
    logic             out_free;

    // Varint step on the incoming byte
    assign shifted    = {57'd0, msg_byte[6:0]} << shift_reg[5:0];
    assign accum_take = shift_reg[6] ? accum_reg : (accum_reg | shifted);
    assign shift_inc  = shift_reg + SHIFT_STEP;
    assign v_done     = !msg_byte[7];
    assign v_long     = msg_byte[7] && (shift_inc > SHIFT_MAX);
    assign remain_dec = remain_reg - 64'd1;
    assign is_ws      = (msg_byte <= WS_MAX);

    // Parse state update for one input byte
    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        seen_next   = seen_reg;
        pcount_next = pcount_reg;
        fstat_next  = fstat_reg;
        ram_we      = 1'b0;
        emit_byte   = 1'b0;
        code_now    = fstat_reg;
        unique case (phase_reg) inside
            PH_KEY:
            begin
                accum_next = accum_take;
                if (v_long)
                begin
                    phase_next = PH_BAD;
                end
                else if (v_done)
                begin
                    accum_next = '0;
                    shift_next = '0;
                    if (accum_take[34:3] == target_field && accum_take[2:0] == WT_LEN)
                    begin
                        phase_next = PH_LEN_TGT;
                    end
                    else
                    begin
                        case (accum_take[2:0])
                            WT_VARINT: phase_next = PH_VARINT;
                            WT_I64:
                            begin
                                remain_next = 64'd8;
                                phase_next  = PH_SKIP;
                            end
                            WT_I32:
                            begin
                                remain_next = 64'd4;
                                phase_next  = PH_SKIP;
                            end
                            WT_LEN:    phase_next = PH_LEN_SKIP;
                            default:   phase_next = PH_BAD;
                        endcase
                    end
                end
                else
                begin
                    shift_next = shift_inc;
                end
            end
            PH_VARINT:
            begin
                accum_next = accum_take;
                if (v_long)
                begin
                    phase_next = PH_BAD;
                end
                else if (v_done)
                begin
                    accum_next = '0;
                    shift_next = '0;
                    phase_next = PH_KEY;
                end
                else
                begin
                    shift_next = shift_inc;
                end
            end
            PH_LEN_SKIP, PH_LEN_TGT:
            begin
                accum_next = accum_take;
                if (v_long)
                begin
                    phase_next = PH_BAD;
                end
                else if (v_done)
                begin
                    remain_next = accum_take;
                    accum_next  = '0;
                    shift_next  = '0;
                    if (phase_reg == PH_LEN_SKIP)
                    begin
                        phase_next = (accum_take == 64'd0) ? PH_KEY : PH_SKIP;
                    end
                    else if (accum_take == 64'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next  = PH_STRING;
                        seen_next   = 1'b0;
                        pcount_next = '0;
                    end
                end
                else
                begin
                    shift_next = shift_inc;
                end
            end
            PH_SKIP:
            begin
                remain_next = remain_dec;
                if (remain_dec == 64'd0)
                begin
                    phase_next = PH_KEY;
                end
            end
            PH_STRING:
            begin
                if (is_ws)
                begin
                    // Interior whitespace is held back until text follows
                    if (seen_reg)
                    begin
                        if (pcount_reg < CNT_W'(SPACE_DEPTH))
                        begin
                            ram_we      = 1'b1;
                            pcount_next = pcount_reg + CNT_W'(1);
                        end
                        else
                        begin
                            fstat_next = psfe_pkg::ST_OVERFLOW;
                        end
                    end
                end
                else
                begin
                    emit_byte   = 1'b1;
                    pcount_next = '0;
                    seen_next   = 1'b1;
                    if (fstat_reg == psfe_pkg::ST_NULL)
                    begin
                        fstat_next = psfe_pkg::ST_FOUND;
                    end
                end
                remain_next = remain_dec;
                if (remain_dec == 64'd0)
                begin
                    phase_next  = PH_DONE;
                    pcount_next = '0;
                end
            end
            default:
            begin
                // done or malformed: ignore the rest
            end
        endcase

        // End of message: pick the status and clear parse state
        if (msg_last)
        begin
            if (phase_next == PH_DONE || (phase_next == PH_KEY && shift_next == 7'd0))
            begin
                code_now = fstat_next;
            end
            else
            begin
                code_now = psfe_pkg::ST_MALFORMED;
            end
            phase_next  = PH_KEY;
            accum_next  = '0;
            shift_next  = '0;
            remain_next = '0;
            seen_next   = 1'b0;
            pcount_next = '0;
            fstat_next  = psfe_pkg::ST_NULL;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            accum_reg  <= '0;
            shift_reg  <= '0;
            remain_reg <= '0;
            seen_reg   <= 1'b0;
            pcount_reg <= '0;
            fstat_reg  <= psfe_pkg::ST_NULL;
        end
        else if (cmd.accept)
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            seen_reg   <= seen_next;
            pcount_reg <= pcount_next;
            fstat_reg  <= fstat_next;
        end
    end

    // Per-item hold registers for results sent after the accept cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_hold_reg <= msg_byte;
            last_hold_reg <= msg_last;
            code_hold_reg <= code_now;
            fcnt_hold_reg <= pcount_reg;
        end
    end

    // Held-back whitespace store
    psfe_ram #(
        .WIDTH (8),
        .DEPTH (SPACE_DEPTH)
    ) u_space_ram (
        .clk   (clk),
        .we    (cmd.accept && ram_we),
        .waddr (pcount_reg[ADDR_W-1:0]),
        .wdata (msg_byte),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Status to controller
    assign out_free        = !out_valid_reg || out_ready;
    assign stat.has_byte   = emit_byte;
    assign stat.has_status = msg_last;
    assign stat.flush_any  = emit_byte && (pcount_reg != '0);
    assign stat.last_hold  = last_hold_reg;
    assign stat.out_free   = out_free;
    assign flush_cnt       = fcnt_hold_reg;

    // Accept cycle uses the live values, later cycles the held ones
    assign byte_val = cmd.accept ? msg_byte : byte_hold_reg;
    assign code_val = cmd.accept ? code_now : code_hold_reg;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            run_last_reg <= cmd.run_last;
            case (cmd.sel)
                psfe_pkg::SEL_FLUSH:
                begin
                    out_byte_reg    <= ram_rdata;
                    is_status_reg   <= 1'b0;
                    status_code_reg <= psfe_pkg::ST_FOUND;
                end
                psfe_pkg::SEL_BYTE:
                begin
                    out_byte_reg    <= byte_val;
                    is_status_reg   <= 1'b0;
                    status_code_reg <= psfe_pkg::ST_FOUND;
                end
                default:
                begin
                    out_byte_reg    <= 8'd0;
                    is_status_reg   <= 1'b1;
                    status_code_reg <= code_val;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_status   = is_status_reg;
    assign status_code = status_code_reg;
    assign run_last    = run_last_reg;

endmodule
`default_nettype wire

// File: rtl/protobuf_string_field_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// Output: an item's first result is loaded into the free output register at accept,
// or after a registered whitespace store read when held-back whitespace goes first.
// Throughput: one item per cycle while no whitespace is flushed, no status follows a
// string byte and the output side takes results; input waits while held bytes pass
// the store's one registered read port, and while such a status goes out.
// Reset: target_field returns to 1 and parse state clears; whitespace store uncleared.
// ----------------------------------------------------------------------------
// protobuf_string_field_extractor: top level
// Extracts one trimmed length-delimited field from a protobuf message byte
// stream and reports an end-of-message status. APB register for the target.
// ----------------------------------------------------------------------------
module protobuf_string_field_extractor #(
    parameter int SPACE_DEPTH = psfe_pkg::SPACE_DEPTH_DEF,
    localparam int CNT_W  = $clog2(SPACE_DEPTH + 1),
    localparam int ADDR_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    psfe_in_if.sink          in_ch,
    psfe_out_if.source       out_ch
);

    // Register index of target_field
    localparam logic REG_TARGET = 1'b0;

    logic [31:0]       target_reg;
    logic              cfg_wr;
    psfe_pkg::cmd_t    cmd;
    psfe_pkg::stat_t   stat;
    logic [CNT_W-1:0]  flush_cnt;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_ready;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= psfe_pkg::TARGET_RESET;
        end
        else if (cfg_wr)
        begin
            target_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_TARGET) ? target_reg : 32'd0;

    // Controller
    psfe_ctrl #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .stat      (stat),
        .flush_cnt (flush_cnt),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    assign in_ch.ready = in_ready;

    // Datapath
    psfe_dpath #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_field (target_reg),
        .msg_byte     (in_ch.msg_byte),
        .msg_last     (in_ch.msg_last),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .stat         (stat),
        .flush_cnt    (flush_cnt),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_byte     (out_ch.out_byte),
        .is_status    (out_ch.is_status),
        .status_code  (out_ch.status_code),
        .run_last     (out_ch.run_last)
    );

endmodule
`default_nettype wire
